### rtl/mapc_pkg.sv
// mapc_pkg: types, codes and constants for the msr access policy checker
// no dependencies
`default_nettype none
package mapc_pkg;

    localparam int RULE_SLOTS_DEF = 32;
    localparam int IDX_W          = 5;
    localparam int ADDR_W         = 5;

    localparam logic [1:0] ACT_PASS = 2'd0;
    localparam logic [1:0] ACT_VIRT = 2'd1;
    localparam logic [1:0] ACT_GP   = 2'd2;
    localparam logic [1:0] ACT_UD   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_GP      = 2'd1;
    localparam logic [1:0] ST_UD      = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [2:0] RA_PASS = 3'd0;
    localparam logic [2:0] RA_VIRT = 3'd1;
    localparam logic [2:0] RA_GP   = 3'd2;
    localparam logic [2:0] RA_UD   = 3'd3;

    localparam logic [31:0] MSR_TSC      = 32'h0000_0010;
    localparam logic [31:0] MSR_PAT      = 32'h0000_0277;
    localparam logic [31:0] MSR_DEBUGCTL = 32'h0000_01D9;
    localparam logic [31:0] MSR_XSS      = 32'h0000_0DA0;
    localparam logic [31:0] MSR_U_CET    = 32'h0000_06A0;
    localparam logic [31:0] MSR_S_CET    = 32'h0000_06A2;
    localparam logic [31:0] MSR_EFER     = 32'hC000_0080;

    localparam logic [ADDR_W-1:0] REG_PERMIT = 5'd0;
    localparam logic [ADDR_W-1:0] REG_LEVEL  = 5'd8;
    localparam logic [ADDR_W-1:0] REG_GEN    = 5'd16;
    localparam logic [ADDR_W-1:0] REG_ACTIVE = 5'd24;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [31:0] msr_number;
        logic        is_write;
        logic [63:0] access_value;
        logic [4:0]  entry_index;
        logic [2:0]  entry_read_action;
        logic [2:0]  entry_write_action;
        logic [63:0] entry_read_mask;
        logic [63:0] entry_write_allowed;
        logic [63:0] entry_write_forced;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  action;
        logic [63:0] result_value;
        logic [63:0] generation_tag;
        logic [31:0] echo_msr;
        logic        echo_write;
    } t_out_beat;

    typedef struct packed {
        logic [31:0] msr;
        logic [2:0]  ra;
        logic [2:0]  wa;
        logic [63:0] rmask;
        logic [63:0] wallowed;
        logic [63:0] wforced;
    } t_rule;

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_OUTER, S_INNER, S_TAIL, S_DONE
    } t_state;

    function automatic logic passthru_ok(input logic [4:0] pf, input logic [31:0] msr);
        logic r;
        if (!pf[0])                 r = 1'b0;
        else if (msr == MSR_TSC)    r = pf[1];
        else if (msr == MSR_PAT)    r = pf[2];
        else if (msr == MSR_DEBUGCTL) r = pf[3];
        else if (msr == MSR_XSS || msr == MSR_U_CET || msr == MSR_S_CET) r = pf[4];
        else                        r = (msr != MSR_EFER);
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/mapc_rule_ram.sv
// mapc_rule_ram: rule table storage, one write port and two registered read ports
// depends on mapc_pkg
`default_nettype none
module mapc_rule_ram
    import mapc_pkg::*;
#(
    parameter int SLOTS = RULE_SLOTS_DEF,
    parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_rule         i_wdata,
    input  wire logic [AW-1:0] i_raddr_a,
    input  wire logic [AW-1:0] i_raddr_b,
    output t_rule              o_rdata_a,
    output t_rule              o_rdata_b
);
    t_rule r_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire

### rtl/msr_access_policy_checker_unit.sv
// msr_access_policy_checker_unit: top level, sequencer over the rule table
// depends on mapc_pkg, mapc_rule_ram
//
// channel | direction | handshake         | payload
// in      | input     | valid / stall out | t_in_beat
// out     | output    | valid / stall in  | t_out_beat
// cfg     | input     | apb write / read  | 4 registers at 8-byte steps
//
// a load beat is written into the table as it is taken; an evaluate beat holds the input
// until its decision is handed to the output register, longer with more active rules
// the single compare unit visits each slot, then each earlier active slot for duplicates
// after reset the table is cleared one slot a cycle, input stalled
// input is stalled while an evaluate beat is in work; a finished decision waits in the
// sequencer while the previous one is still held on a stalled output
`default_nettype none
module msr_access_policy_checker_unit
    import mapc_pkg::*;
#(
    parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire t_in_beat          i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output t_out_beat              o_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [63:0]       pwdata,
    output logic [63:0]            prdata,
    output logic                   pready
);
    localparam int AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] SLOTS_C = CW'(RULE_SLOTS);

    // config registers
    logic [4:0]  r_permit;
    logic [1:0]  r_level;
    logic [63:0] r_gen;
    logic [5:0]  r_active;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_permit <= '0; r_level <= '0; r_gen <= '0; r_active <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                REG_PERMIT: r_permit <= pwdata[4:0];
                REG_LEVEL:  r_level  <= pwdata[1:0];
                REG_GEN:    r_gen    <= pwdata;
                REG_ACTIVE: r_active <= pwdata[5:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr)
            REG_PERMIT: prdata = {59'd0, r_permit};
            REG_LEVEL:  prdata = {62'd0, r_level};
            REG_GEN:    prdata = r_gen;
            REG_ACTIVE: prdata = {58'd0, r_active};
            default:    prdata = '0;
        endcase
    end

    // sequencer state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_i, n_i;      // outer index
    logic [CW-1:0]   r_j, n_j;      // inner index
    logic            r_bad, n_bad;
    logic            r_found, n_found;
    logic [AW-1:0]   r_slot, n_slot;
    logic            r_rd, n_rd;    // a read issued last cycle, data valid now
    t_in_beat        r_item;
    logic            r_ov, n_ov;
    t_out_beat       r_out, n_out;

    logic            we;
    logic [AW-1:0]   waddr, ra, rb;
    t_rule           wdata, qa, qb;

    mapc_rule_ram #(.SLOTS(RULE_SLOTS), .AW(AW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr_a(ra), .i_raddr_b(rb), .o_rdata_a(qa), .o_rdata_b(qb)
    );

    logic accept;
    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    // rule count too large: walk every slot, the policy is invalid anyway
    logic [CW-1:0] act_n;
    assign act_n = (32'(r_active) > 32'(RULE_SLOTS)) ? SLOTS_C : CW'(r_active);

    // per-rule checks on port a data
    logic rule_bad, unused_bad, ra_f, wa_f;
    always_comb begin
        ra_f = (qa.ra == RA_GP) || (qa.ra == RA_UD);
        wa_f = (qa.wa == RA_GP) || (qa.wa == RA_UD);
        rule_bad = (qa.ra > RA_UD) || (qa.wa > RA_UD)
                || ((qa.wforced & ~qa.wallowed) != 64'd0)
                || (ra_f && qa.rmask != 64'd0)
                || (wa_f && (qa.wallowed != 64'd0 || qa.wforced != 64'd0))
                || (((qa.ra == RA_PASS) || (qa.wa == RA_PASS))
                    && !passthru_ok(r_permit, qa.msr));
        unused_bad = (qa != '0);
    end

    // final decision using matched slot data on port b
    t_out_beat fin;
    always_comb begin
        logic [2:0] a;
        logic       gl;
        fin.generation_tag = r_gen;
        fin.echo_msr       = r_item.msr_number;
        fin.echo_write     = r_item.is_write;
        fin.result_value   = '0;
        fin.status         = ST_GP;
        fin.action         = ACT_GP;
        a  = r_item.is_write ? qb.wa : qb.ra;
        gl = (r_level == 2'd1 || r_level == 2'd2) && (r_gen != 64'd0)
             && (32'(r_active) <= 32'(RULE_SLOTS));
        if (!gl || r_bad) begin
            fin.status = ST_INVALID;
        end else if (r_found) begin
            if (a == RA_PASS) begin
                if (passthru_ok(r_permit, r_item.msr_number)) begin
                    fin.status = ST_OK; fin.action = ACT_PASS;
                    fin.result_value = r_item.access_value;
                end
            end else if (a == RA_VIRT) begin
                if (r_item.is_write) begin
                    if ((r_item.access_value & ~qb.wallowed) == 64'd0) begin
                        fin.status = ST_OK; fin.action = ACT_VIRT;
                        fin.result_value = (r_item.access_value & qb.wallowed) | qb.wforced;
                    end
                end else begin
                    fin.status = ST_OK; fin.action = ACT_VIRT;
                    fin.result_value = r_item.access_value & qb.rmask;
                end
            end else if (a == RA_UD) begin
                fin.status = ST_UD; fin.action = ACT_UD;
            end
        end
    end

    always_comb begin
        n_state = r_state; n_i = r_i; n_j = r_j; n_bad = r_bad;
        n_found = r_found; n_slot = r_slot; n_rd = 1'b0;
        n_ov = r_ov && i_stall; n_out = r_out;
        we = 1'b0; waddr = r_i[AW-1:0]; wdata = '0;
        ra = r_i[AW-1:0]; rb = r_j[AW-1:0];
        case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                n_i = r_i + 1'b1;
                if (r_i == SLOTS_C - 1'b1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_data.operation == OP_LOAD) begin
                        we    = (32'(i_data.entry_index) < 32'(RULE_SLOTS));
                        waddr = AW'(i_data.entry_index);
                        wdata.msr      = i_data.msr_number;
                        wdata.ra       = i_data.entry_read_action;
                        wdata.wa       = i_data.entry_write_action;
                        wdata.rmask    = i_data.entry_read_mask;
                        wdata.wallowed = i_data.entry_write_allowed;
                        wdata.wforced  = i_data.entry_write_forced;
                    end else begin
                        n_state = S_OUTER; n_i = '0; n_bad = 1'b0; n_found = 1'b0;
                        n_slot = '0;
                    end
                end
            end
            S_OUTER: begin
                // issue read of slot i (port a), inner loop compares against j<i
                if (r_rd) begin
                    // data for outer slot r_i is on qa now
                    if (r_i < act_n) begin
                        if (rule_bad) n_bad = 1'b1;
                        if (!r_found && qa.msr == r_item.msr_number) begin
                            n_found = 1'b1; n_slot = r_i[AW-1:0];
                        end
                    end else if (unused_bad) begin
                        n_bad = 1'b1;
                    end
                    n_j = '0;
                    n_state = (r_i < act_n && r_i != '0) ? S_INNER : S_TAIL;
                    if (r_i < act_n && r_i != '0) n_rd = 1'b1;
                    ra = r_i[AW-1:0]; rb = '0;
                end else begin
                    n_rd = 1'b1;
                end
            end
            S_INNER: begin
                // qb holds slot r_j, qa holds slot r_i
                ra = r_i[AW-1:0];
                if (qb.msr == qa.msr) n_bad = 1'b1;
                if (r_j + 1'b1 < r_i) begin
                    n_j = r_j + 1'b1; rb = AW'(r_j + 1'b1);
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                rb = r_slot;
                if (r_i == SLOTS_C - 1'b1) begin
                    n_state = S_DONE;
                end else begin
                    n_i = r_i + 1'b1; n_state = S_OUTER;
                end
            end
            S_DONE: begin
                // hold the matched slot on port b until the output register is free
                rb = r_slot;
                if (!r_ov || !i_stall) begin
                    n_out = fin; n_ov = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_i <= '0; r_j <= '0; r_bad <= 1'b0;
            r_found <= 1'b0; r_slot <= '0; r_rd <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_i <= n_i; r_j <= n_j; r_bad <= n_bad;
            r_found <= n_found; r_slot <= n_slot; r_rd <= n_rd;
            r_ov <= n_ov;
        end
    end
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) r_item <= i_data;
    end
endmodule
`default_nettype wire

### dv/mapc_policy_scoreboard.sv
// mapc_policy_scoreboard: watches the in, out and cfg ports of the msr access policy checker,
// predicts every decision and compares it with what comes out
// depends on mapc_pkg
`timescale 1ns / 1ps
module mapc_policy_scoreboard
    import mapc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire t_in_beat          i_in_data,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire t_out_beat         i_out_data,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic              i_pready,
    input  wire logic [ADDR_W-1:0] i_paddr,
    input  wire logic [63:0]       i_pwdata,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_decisions
);

    localparam int SLOTS = 32;

    t_rule       rules [SLOTS];
    logic [4:0]  permit;
    logic [1:0]  level;
    logic [63:0] generation;
    logic [5:0]  active;
    t_out_beat   decisions_q[$];

    function automatic logic pass_allowed(input logic [31:0] msr);
        if (!permit[0]) return 1'b0;
        if (msr == MSR_TSC) return permit[1];
        if (msr == MSR_PAT) return permit[2];
        if (msr == MSR_DEBUGCTL) return permit[3];
        if (msr == MSR_XSS || msr == MSR_U_CET || msr == MSR_S_CET) return permit[4];
        return msr != MSR_EFER;
    endfunction

    function automatic logic policy_valid();
        if (level != 2'd1 && level != 2'd2) return 1'b0;
        if (active > SLOTS) return 1'b0;
        if (generation == 64'd0) return 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (i < active) begin
                if (rules[i].ra > RA_UD || rules[i].wa > RA_UD) return 1'b0;
                if ((rules[i].wforced & ~rules[i].wallowed) != 0) return 1'b0;
                if ((rules[i].ra == RA_GP || rules[i].ra == RA_UD) && rules[i].rmask != 0)
                    return 1'b0;
                if ((rules[i].wa == RA_GP || rules[i].wa == RA_UD) &&
                    (rules[i].wallowed != 0 || rules[i].wforced != 0))
                    return 1'b0;
                if ((rules[i].ra == RA_PASS || rules[i].wa == RA_PASS) &&
                    !pass_allowed(rules[i].msr))
                    return 1'b0;
                for (int j = 0; j < i; j++)
                    if (rules[j].msr == rules[i].msr) return 1'b0;
            end else if (rules[i] != '0) begin
                // unused slots must be fully clear
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_out_beat decide(input t_in_beat b);
        t_out_beat d;
        int        hit;
        logic [2:0] a;
        d = '0;
        d.generation_tag = generation;
        d.echo_msr = b.msr_number;
        d.echo_write = b.is_write;
        d.status = ST_GP;
        d.action = ACT_GP;
        hit = -1;
        if (!policy_valid()) begin
            d.status = ST_INVALID;
            return d;
        end
        for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && i < active && rules[i].msr == b.msr_number) hit = i;
        if (hit < 0) return d;
        a = b.is_write ? rules[hit].wa : rules[hit].ra;
        if (a == RA_PASS) begin
            if (pass_allowed(b.msr_number)) begin
                d.status = ST_OK;
                d.action = ACT_PASS;
                d.result_value = b.access_value;
            end
        end else if (a == RA_VIRT) begin
            if (!b.is_write) begin
                d.status = ST_OK;
                d.action = ACT_VIRT;
                d.result_value = b.access_value & rules[hit].rmask;
            end else if ((b.access_value & ~rules[hit].wallowed) == 0) begin
                d.status = ST_OK;
                d.action = ACT_VIRT;
                d.result_value = (b.access_value & rules[hit].wallowed) | rules[hit].wforced;
            end
        end else if (a == RA_UD) begin
            d.status = ST_UD;
            d.action = ACT_UD;
        end
        return d;
    endfunction

    assign o_pending = decisions_q.size();

    always @(posedge i_clk) begin
        t_out_beat want;
        t_rule     r;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) rules[i] = '0;
            permit = '0;
            level = '0;
            generation = '0;
            active = '0;
            decisions_q.delete();
            o_fail_count = 0;
            o_decisions = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    REG_PERMIT: permit = i_pwdata[4:0];
                    REG_LEVEL:  level = i_pwdata[1:0];
                    REG_GEN:    generation = i_pwdata;
                    REG_ACTIVE: active = i_pwdata[5:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.operation == OP_LOAD) begin
                    r.msr = i_in_data.msr_number;
                    r.ra = i_in_data.entry_read_action;
                    r.wa = i_in_data.entry_write_action;
                    r.rmask = i_in_data.entry_read_mask;
                    r.wallowed = i_in_data.entry_write_allowed;
                    r.wforced = i_in_data.entry_write_forced;
                    rules[i_in_data.entry_index] = r;
                end else begin
                    decisions_q.push_back(decide(i_in_data));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                o_decisions++;
                if (decisions_q.size() == 0) begin
                    o_fail_count++;
                    $display("%t decision beat exp none got %h", $time, i_out_data);
                end else begin
                    want = decisions_q.pop_front();
                    if (want.status != i_out_data.status) begin
                        o_fail_count++;
                        $display("%t status exp %0d got %0d", $time, want.status,
                                 i_out_data.status);
                    end
                    if (want.action != i_out_data.action) begin
                        o_fail_count++;
                        $display("%t action exp %0d got %0d", $time, want.action,
                                 i_out_data.action);
                    end
                    if (want.result_value != i_out_data.result_value) begin
                        o_fail_count++;
                        $display("%t value exp %h got %h", $time, want.result_value,
                                 i_out_data.result_value);
                    end
                    if (want.generation_tag != i_out_data.generation_tag) begin
                        o_fail_count++;
                        $display("%t generation exp %h got %h", $time, want.generation_tag,
                                 i_out_data.generation_tag);
                    end
                    if (want.echo_msr != i_out_data.echo_msr) begin
                        o_fail_count++;
                        $display("%t msr exp %h got %h", $time, want.echo_msr,
                                 i_out_data.echo_msr);
                    end
                    if (want.echo_write != i_out_data.echo_write) begin
                        o_fail_count++;
                        $display("%t write flag exp %0d got %0d", $time, want.echo_write,
                                 i_out_data.echo_write);
                    end
                end
            end
        end
    end

endmodule

### dv/tb_msr_access_policy_checker_unit.sv
// tb_msr_access_policy_checker_unit: stimulus and verdict for the msr access policy checker
// depends on mapc_pkg, msr_access_policy_checker_unit, mapc_policy_scoreboard
`timescale 1ns / 1ps
module tb_msr_access_policy_checker_unit;
    import mapc_pkg::*;

    localparam int SLOTS = 32;
    localparam longint CYCLE_LIMIT = 4_000_000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    t_in_beat          i_data;
    logic              o_valid;
    logic              i_stall;
    t_out_beat         o_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;

    int     fail_count;
    int     pending;
    int     decisions;
    int     beats_sent;
    int     evals_sent;
    longint cycle;

    // idle modes: 0 none, 1 sender gaps, 2 receiver stalls, 3 both at low rate
    int          idle_mode;
    // shadow of what the table holds, used to aim accesses at loaded rules
    logic [31:0] shadow_msr [SLOTS];
    logic [63:0] shadow_wal [SLOTS];
    logic        shadow_used[SLOTS];

    msr_access_policy_checker_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mapc_policy_scoreboard scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_decisions  (decisions)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog against a hung handshake
    initial cycle = 0;
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT) begin
            $display("timeout at cycle %0d, %0d decisions outstanding", cycle, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver back-pressure, chosen per phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            case (idle_mode)
                2:       i_stall <= ($urandom_range(0, 99) < 45);
                3:       i_stall <= ($urandom_range(0, 99) < 14);
                default: i_stall <= 1'b0;
            endcase
        end
    end

    // apb write, setup phase then access phase
    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // present one beat and hold it until the block takes it
    task automatic send_beat(input t_in_beat b);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 45 : (idle_mode == 3) ? 14 : 0;
        if ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_sent++;
        if (b.operation == OP_EVAL) begin
            evals_sent++;
        end
    endtask

    task automatic load_rule(input logic [4:0] idx, input logic [31:0] msr,
                             input logic [2:0] ra, input logic [2:0] wa,
                             input logic [63:0] rmask, input logic [63:0] wal,
                             input logic [63:0] wfo);
        t_in_beat b;
        b = '0;
        b.operation = OP_LOAD;
        b.entry_index = idx;
        b.msr_number = msr;
        b.entry_read_action = ra;
        b.entry_write_action = wa;
        b.entry_read_mask = rmask;
        b.entry_write_allowed = wal;
        b.entry_write_forced = wfo;
        // fields the load ignores still get random content
        b.is_write = 1'($urandom_range(0, 1));
        b.access_value = {$urandom, $urandom};
        shadow_msr[idx] = msr;
        shadow_wal[idx] = wal;
        shadow_used[idx] = (b != '0);
        send_beat(b);
    endtask

    task automatic access(input logic [31:0] msr, input logic wr, input logic [63:0] value);
        t_in_beat     b;
        logic [319:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom};
        b = raw[$bits(t_in_beat)-1:0];
        b.operation = OP_EVAL;
        b.msr_number = msr;
        b.is_write = wr;
        b.access_value = value;
        send_beat(b);
    endtask

    // wait for every decision, then let a trailing load settle before touching registers
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_policy(input logic [4:0] pf, input logic [1:0] lvl,
                              input logic [63:0] gen, input logic [5:0] n);
        reg_write(REG_PERMIT, {59'd0, pf});
        reg_write(REG_LEVEL, {62'd0, lvl});
        reg_write(REG_GEN, gen);
        reg_write(REG_ACTIVE, {58'd0, n});
    endtask

    function automatic logic [31:0] pick_msr();
        case ($urandom_range(0, 9))
            0: return MSR_TSC;
            1: return MSR_PAT;
            2: return MSR_DEBUGCTL;
            3: return MSR_XSS;
            4: return MSR_U_CET;
            5: return MSR_S_CET;
            6: return MSR_EFER;
            7: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // well-formed table of n rules with random content, a little noise mixed in
    task automatic build_table(input int n, input logic [4:0] pf);
        logic [31:0] msr;
        logic [2:0]  ra;
        logic [2:0]  wa;
        logic [63:0] rmask;
        logic [63:0] wal;
        logic [63:0] wfo;
        logic        dup;
        for (int i = 0; i < SLOTS; i++) begin
            if (i < n) begin
                do begin
                    msr = pick_msr();
                    dup = 1'b0;
                    for (int j = 0; j < i; j++) if (shadow_msr[j] == msr) dup = 1'b1;
                end while (dup && $urandom_range(0, 49) != 0);
                ra = 3'($urandom_range(0, 3));
                wa = 3'($urandom_range(0, 3));
                // pass-through only where the permit bits can allow it, mostly
                if (!pf[0] || msr == MSR_EFER) begin
                    if (ra == RA_PASS) ra = RA_VIRT;
                    if (wa == RA_PASS) wa = RA_VIRT;
                end
                rmask = (ra == RA_GP || ra == RA_UD) ? 64'd0 : {$urandom, $urandom};
                wal = (wa == RA_GP || wa == RA_UD) ? 64'd0 : {$urandom, $urandom};
                wfo = wal & {$urandom, $urandom};
                if ($urandom_range(0, 59) == 0) ra = 3'($urandom_range(4, 7));
                if ($urandom_range(0, 59) == 0) wfo = {$urandom, $urandom};
                load_rule(5'(i), msr, ra, wa, rmask, wal, wfo);
            end else if (shadow_used[i]) begin
                if ($urandom_range(0, 29) == 0) begin
                    // stale slot left behind now and then
                    load_rule(5'(i), $urandom, 3'd0, 3'd0, 64'd0, 64'd0, 64'd0);
                end else begin
                    load_rule(5'(i), 32'd0, 3'd0, 3'd0, 64'd0, 64'd0, 64'd0);
                end
            end
        end
    endtask

    task automatic random_accesses(input int n, input int rules);
        logic [31:0] msr;
        logic        wr;
        logic [63:0] value;
        int          k;
        for (int i = 0; i < n; i++) begin
            k = (rules > 0) ? $urandom_range(0, rules - 1) : 0;
            msr = (rules > 0 && $urandom_range(0, 9) < 8) ? shadow_msr[k] : pick_msr();
            wr = 1'($urandom_range(0, 1));
            value = {$urandom, $urandom};
            // half the writes stay within the allowed bits to reach the virtualized result
            if (wr && rules > 0 && $urandom_range(0, 1)) value = value & shadow_wal[k];
            access(msr, wr, value);
        end
    endtask

    initial begin
        int          n;
        logic [4:0]  pf;
        logic [1:0]  lvl;
        logic [63:0] gen;
        int          phase;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_mode = 0;
        beats_sent = 0;
        evals_sent = 0;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_msr[i] = '0;
            shadow_wal[i] = '0;
            shadow_used[i] = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset policy is invalid (level 0, generation 0)
        access(MSR_TSC, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        drain();
        // too many rules
        set_policy(5'h1F, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
        access(32'hFFFF_FFFF, 1'b1, 64'd0);
        drain();
        set_policy(5'h1F, 2'd1, 64'd1, 6'd33);
        access(MSR_PAT, 1'b0, 64'h1);
        drain();
        // empty table, valid policy: no match
        set_policy(5'h00, 2'd2, 64'h8000_0000_0000_0000, 6'd0);
        access(32'h0, 1'b0, 64'h5);
        drain();
        // hand-built rules: pass, virtualize, gp, ud, and efer pass that is never allowed
        set_policy(5'h1F, 2'd1, 64'hDEAD_BEEF_0000_0001, 6'd4);
        load_rule(5'd0, MSR_TSC, RA_PASS, RA_VIRT, 64'd0, 64'h0000_0000_FFFF_FFFF,
                  64'h0000_0000_0000_0100);
        load_rule(5'd1, MSR_PAT, RA_VIRT, RA_GP, 64'hFF00_FF00_FF00_FF00, 64'd0, 64'd0);
        load_rule(5'd2, MSR_S_CET, RA_UD, RA_UD, 64'd0, 64'd0, 64'd0);
        load_rule(5'd3, 32'h1234_5678, RA_VIRT, RA_PASS, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'd0, 64'd0);
        access(MSR_TSC, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        access(MSR_TSC, 1'b1, 64'h0000_0000_1234_5678);
        access(MSR_TSC, 1'b1, 64'h0000_0001_0000_0000);
        access(MSR_PAT, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        access(MSR_PAT, 1'b1, 64'h1);
        access(MSR_S_CET, 1'b0, 64'h1);
        access(32'h1234_5678, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        // rule with an invalid action code and all mask bits set, loaded into an unused slot
        load_rule(5'd31, 32'hFFFF_FFFF, 3'd7, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        access(MSR_TSC, 1'b0, 64'h1);
        load_rule(5'd31, 32'd0, 3'd0, 3'd0, 64'd0, 64'd0, 64'd0);
        load_rule(5'd3, MSR_EFER, RA_PASS, RA_VIRT, 64'd0, 64'd0, 64'd0);
        access(MSR_EFER, 1'b0, 64'h1);
        drain();
        // permit bits cleared for the special msr pass-through
        set_policy(5'h01, 2'd2, 64'd7, 6'd4);
        access(MSR_TSC, 1'b0, 64'h3);
        drain();

        // random phases: fresh policy, table and accesses under each idle mode
        phase = 0;
        while (beats_sent < 850) begin
            idle_mode = phase % 4;
            case ($urandom_range(0, 5))
                0:       n = 0;
                1:       n = SLOTS;
                default: n = $urandom_range(1, 6);
            endcase
            pf = ($urandom_range(0, 3) != 0) ? 5'h1F : 5'($urandom);
            lvl = ($urandom_range(0, 9) != 0) ? 2'($urandom_range(1, 2)) : 2'($urandom);
            gen = ($urandom_range(0, 19) != 0) ? {$urandom, $urandom} : 64'd0;
            if ($urandom_range(0, 19) == 0) n = $urandom_range(33, 63);
            set_policy(pf, lvl, gen, 6'(n));
            build_table((n > SLOTS) ? SLOTS : n, pf);
            random_accesses($urandom_range(4, 12), (n > SLOTS) ? SLOTS : n);
            drain();
            phase++;
        end

        repeat (50) @(posedge i_clk);
        $display("sent %0d beats (%0d accesses, rest rule loads) over %0d policy phases",
                 beats_sent, evals_sent, phase);
        $display("checked %0d decisions, %0d mismatches", decisions, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
